// ----- rtl/assert_macros.svh -----
// assertion macros used by the decoder rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wrsd_pkg.sv -----
// types, constants and byte unmap function of the word replacement stream decoder
package wrsd_pkg;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_WORD    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TYPE     = 2'd1,
    ERR_MARKER   = 2'd2,
    ERR_UNKNOWN  = 2'd3
  } err_e;

  localparam logic [7:0]  HeaderMagic   = 8'h07;
  localparam logic [7:0]  CtrlEscape    = 8'h0C;
  localparam logic [7:0]  CtrlUpper     = 8'h07;
  localparam logic [7:0]  CtrlCapital   = 8'h40;
  localparam logic [7:0]  CtrlUpperOff  = 8'h06;
  localparam logic [7:0]  CodeOneMin    = 8'h80;
  localparam logic [7:0]  CodeOneMax    = 8'hCF;
  localparam logic [7:0]  CodeTwoMin    = 8'hD0;
  localparam logic [7:0]  CodeTwoMax    = 8'hEF;
  localparam logic [7:0]  CodeThreeMin  = 8'hF0;
  localparam logic [15:0] WordsPerRow   = 16'd80;
  localparam logic [15:0] TwoByteBase   = 16'd80;
  localparam logic [15:0] ThreeByteBase = 16'd3920;
  localparam logic [15:0] WordCountRst  = 16'd44880;
  localparam logic [7:0]  CaseOffset    = 8'h20;

  localparam logic [2:0]  HdrType       = 3'd0;
  localparam logic [2:0]  HdrMarker     = 3'd5;
  localparam logic [2:0]  HdrDone       = 3'd6;

  localparam logic        RegWordCount  = 1'b0;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [15:0] word_index;
    logic        first_capital;
    logic        all_upper;
    err_e        error_code;
    logic [31:0] declared_length;
    logic        mid_sequence;
  } res_t;

  function automatic logic [7:0] unmap_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h7B:8'h7E]}) begin
      r = b - 8'h7B + 8'h50;
    end else if (b inside {[8'h50:8'h53]}) begin
      r = b - 8'h50 + 8'h7B;
    end else if (b inside {[8'h3A:8'h3F], [8'h4A:8'h4F]}) begin
      r = b ^ 8'h70;
    end
    if (r == 8'h58 || r == 8'h60) begin
      r = r ^ 8'h38;
    end
    return r;
  endfunction

endpackage

// ----- rtl/word_replacement_stream_decoder.sv -----
// word replacement stream decoder: header check, case controls and dictionary code decode
//
//  channel   | direction | transaction
//  s_axis    | in        | one stored byte of the transformed stream
//  m_axis    | out       | one decode result per stored byte (kind in tuser)
//  apb       | in/out    | word_count register at address 0
//
// one byte per cycle while the skid is empty; a result goes to the result register or skid
// decode state and result are set by a single combinational pass from the input byte
// a two entry output (result register plus skid) takes one more byte during a stall
// reset clears header, case and code state; word_count returns to 44880
// no clearing pass after reset
`include "assert_macros.svh"

module word_replacement_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stored_byte [7:0]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // out_byte [7:0], word_index [23:8], first_capital [24], all_upper [25],
  // error_code [27:26], declared_length [59:28], mid_sequence [60], zero [63:61]
  output logic [63:0] m_axis_tdata,
  // kind [1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] word_count_q;
  logic [2:0]  hdr_q, hdr_d;
  logic [31:0] len_q, len_d;
  logic        upper_q, upper_d;
  logic        cap_q, cap_d;
  logic        esc_q, esc_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  second_q, second_d;
  logic [1:0]  have_q, have_d;
  logic [1:0]  need_q, need_d;

  wrsd_pkg::res_t res;
  wrsd_pkg::res_t out_q;
  wrsd_pkg::res_t skid_q;
  logic           out_v_q;
  logic           skid_v_q;
  logic           in_acc;
  logic           out_load;

  logic [7:0]  b;
  logic [1:0]  done_len;
  logic [15:0] idx;
  logic        idx_bad;
  logic        alpha;
  logic [15:0] idx1;
  logic [15:0] idx2;
  logic [15:0] idx3;
  logic [8:0]  row3;
  logic        ok2;
  logic        ok3;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wrsd_pkg::RegWordCount) ? {16'd0, word_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= wrsd_pkg::WordCountRst;
    end else if (psel && penable && pwrite && pready && paddr[2] == wrsd_pkg::RegWordCount) begin
      word_count_q <= pwdata[15:0];
    end
  end

  // code index candidates
  assign row3 = {first_q[3:0], 5'(second_q - wrsd_pkg::CodeTwoMin)};
  assign idx1 = {8'd0, b - wrsd_pkg::CodeOneMin};
  assign idx2 = wrsd_pkg::TwoByteBase
              + 16'(first_q - wrsd_pkg::CodeTwoMin) * wrsd_pkg::WordsPerRow
              + {8'd0, b - wrsd_pkg::CodeOneMin};
  assign idx3 = wrsd_pkg::ThreeByteBase
              + {7'd0, row3} * wrsd_pkg::WordsPerRow
              + {8'd0, b - wrsd_pkg::CodeOneMin};
  assign ok2  = (b >= wrsd_pkg::CodeOneMin) && (b <= wrsd_pkg::CodeOneMax);
  assign ok3  = ok2 && (first_q >= wrsd_pkg::CodeThreeMin)
             && (second_q >= wrsd_pkg::CodeTwoMin) && (second_q <= wrsd_pkg::CodeTwoMax);

  assign b     = wrsd_pkg::unmap_byte(s_axis_tdata);
  assign alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);

  always_comb begin
    hdr_d    = hdr_q;
    len_d    = len_q;
    upper_d  = upper_q;
    cap_d    = cap_q;
    esc_d    = esc_q;
    first_d  = first_q;
    second_d = second_q;
    have_d   = have_q;
    need_d   = need_q;
    done_len = 2'd0;
    idx      = 16'd0;
    idx_bad  = 1'b0;
    res      = '0;
    res.kind       = wrsd_pkg::KIND_NONE;
    res.error_code = wrsd_pkg::ERR_NONE;

    if (hdr_q != wrsd_pkg::HdrDone) begin
      if (hdr_q == wrsd_pkg::HdrType) begin
        if (s_axis_tdata != wrsd_pkg::HeaderMagic) begin
          res.kind       = wrsd_pkg::KIND_ERROR;
          res.error_code = wrsd_pkg::ERR_TYPE;
        end
      end else if (hdr_q == wrsd_pkg::HdrMarker) begin
        if (s_axis_tdata != wrsd_pkg::HeaderMagic) begin
          res.kind       = wrsd_pkg::KIND_ERROR;
          res.error_code = wrsd_pkg::ERR_MARKER;
        end
      end else begin
        len_d = {len_q[23:0], s_axis_tdata};
      end
      hdr_d = hdr_q + 3'd1;
    end else if (esc_q) begin
      upper_d      = 1'b0;
      esc_d        = 1'b0;
      res.kind     = wrsd_pkg::KIND_LITERAL;
      res.out_byte = b;
    end else if (need_q != 2'd0) begin
      if (have_q == 2'd1) begin
        second_d = b;
        if (b > wrsd_pkg::CodeOneMax) begin
          have_d = 2'd2;
          need_d = 2'd1;
        end else begin
          done_len = 2'd2;
          idx      = idx2;
          idx_bad  = !ok2;
        end
      end else begin
        done_len = 2'd3;
        idx      = idx3;
        idx_bad  = !ok3;
      end
    end else if (b == wrsd_pkg::CtrlEscape) begin
      esc_d = 1'b1;
    end else if (b == wrsd_pkg::CtrlUpper) begin
      upper_d = 1'b1;
    end else if (b == wrsd_pkg::CtrlCapital) begin
      cap_d = 1'b1;
    end else if (b == wrsd_pkg::CtrlUpperOff) begin
      upper_d = 1'b0;
    end else if (b >= wrsd_pkg::CodeOneMin) begin
      first_d = b;
      have_d  = 2'd1;
      if (b > wrsd_pkg::CodeOneMax) begin
        need_d = 2'd1;
      end else begin
        done_len = 2'd1;
        idx      = idx1;
      end
    end else begin
      upper_d      = upper_q && alpha;
      cap_d        = 1'b0;
      res.kind     = wrsd_pkg::KIND_LITERAL;
      res.out_byte = (cap_q || (upper_q && alpha)) ? b - wrsd_pkg::CaseOffset : b;
    end

    if (done_len != 2'd0) begin
      if (idx_bad || idx >= word_count_q) begin
        res.kind       = wrsd_pkg::KIND_ERROR;
        res.error_code = wrsd_pkg::ERR_UNKNOWN;
      end else begin
        res.kind          = wrsd_pkg::KIND_WORD;
        res.word_index    = idx;
        res.first_capital = cap_q;
        res.all_upper     = upper_q;
      end
      cap_d    = 1'b0;
      first_d  = 8'd0;
      second_d = 8'd0;
      have_d   = 2'd0;
      need_d   = 2'd0;
    end

    res.declared_length = len_d;
    res.mid_sequence    = esc_d || (need_d != 2'd0);
  end

  // decode state
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= '0;
      len_q    <= '0;
      upper_q  <= 1'b0;
      cap_q    <= 1'b0;
      esc_q    <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
      have_q   <= '0;
      need_q   <= '0;
    end else if (in_acc) begin
      hdr_q    <= hdr_d;
      len_q    <= len_d;
      upper_q  <= upper_d;
      cap_q    <= cap_d;
      esc_q    <= esc_d;
      first_q  <= first_d;
      second_q <= second_d;
      have_q   <= have_d;
      need_q   <= need_d;
    end
  end

  // result register and skid stage
  assign s_axis_tready = !skid_v_q;
  assign out_load      = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q  <= skid_v_q || in_acc;
      skid_v_q <= 1'b0;
    end else if (in_acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'd0, out_q.mid_sequence, out_q.declared_length, out_q.error_code,
                          out_q.all_upper, out_q.first_capital, out_q.word_index,
                          out_q.out_byte};

  `ASSERT_IMPLY(a_skid_behind_out, skid_v_q, out_v_q, "skid entry without result register")
  `ASSERT_IMPLY(a_kind_matches_err, out_v_q,
                (out_q.kind == wrsd_pkg::KIND_ERROR) == (out_q.error_code != wrsd_pkg::ERR_NONE),
                "error kind and error code disagree")
  `ASSERT_ALWAYS(a_hdr_saturates, hdr_q <= wrsd_pkg::HdrDone, "header position past six")
  `ASSERT_IMPLY(a_need_has_first, need_q != 2'd0, have_q != 2'd0,
                "code pending without a first byte")

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the word replacement stream decoder
module testbench;

  localparam logic [2:0] WordCountAddr = {wrsd_pkg::RegWordCount, 2'b00};
  localparam logic [2:0] UnusedAddr    = 3'd4;
  localparam int         HoldCycles    = 300;
  localparam int         LastWord      = 44879;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  word_replacement_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // stimulus and expectation stores
  logic [7:0]     stored_q[$];
  wrsd_pkg::res_t pending_results[$];
  logic [7:0]     stored_for[256];
  int             queued_total = 0;
  int             error_total = 0;
  int             snd_idle_pct = 0;
  int             rcv_idle_pct = 0;
  logic           hold_armed = 1'b0;
  logic           hold_done = 1'b0;
  int             hold_left = 0;
  wrsd_pkg::res_t oldest;

  // decoder state mirror
  logic [2:0]  hdr_pos = '0;
  logic [31:0] len_reg = '0;
  logic        upper_on = 1'b0;
  logic        cap_pend = 1'b0;
  logic        esc_pend = 1'b0;
  logic [7:0]  code_b0 = '0;
  logic [7:0]  code_b1 = '0;
  logic [1:0]  code_have = '0;
  logic [1:0]  code_need = '0;
  logic [15:0] words_loaded = wrsd_pkg::WordCountRst;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    error_total++;
  endtask

  function automatic logic [7:0] undo_byte_map(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h7B && b <= 8'h7E) r = b - 8'h2B;
    else if (b >= 8'h50 && b <= 8'h53) r = b + 8'h2B;
    else if ((b >= 8'h3A && b <= 8'h3F) || (b >= 8'h4A && b <= 8'h4F)) r = b ^ 8'h70;
    if (r == 8'h58 || r == 8'h60) r = r ^ 8'h38;
    return r;
  endfunction

  // word index of a finished code, bit 16 set when the layout is invalid
  function automatic logic [16:0] code_to_index(input logic [1:0] n, input logic [7:0] b0,
                                                input logic [7:0] b1, input logic [7:0] b2);
    int unsigned u0, u1, u2, v;
    u0 = b0;
    u1 = b1;
    u2 = b2;
    v = 32'h10000;
    if (n == 2'd1) begin
      if (b0 >= wrsd_pkg::CodeOneMin && b0 <= wrsd_pkg::CodeOneMax)
        v = u0 - wrsd_pkg::CodeOneMin;
    end else if (n == 2'd2) begin
      if (b0 >= wrsd_pkg::CodeTwoMin && b1 >= wrsd_pkg::CodeOneMin &&
          b1 <= wrsd_pkg::CodeOneMax)
        v = wrsd_pkg::TwoByteBase + (u0 - wrsd_pkg::CodeTwoMin) * wrsd_pkg::WordsPerRow
            + (u1 - wrsd_pkg::CodeOneMin);
    end else begin
      if (b0 >= wrsd_pkg::CodeThreeMin && b1 >= wrsd_pkg::CodeTwoMin &&
          b1 <= wrsd_pkg::CodeTwoMax && b2 >= wrsd_pkg::CodeOneMin &&
          b2 <= wrsd_pkg::CodeOneMax)
        v = wrsd_pkg::ThreeByteBase
            + ((u0 - wrsd_pkg::CodeThreeMin) * 32 + (u1 - wrsd_pkg::CodeTwoMin))
              * wrsd_pkg::WordsPerRow
            + (u2 - wrsd_pkg::CodeOneMin);
    end
    return v[16:0];
  endfunction

  function automatic wrsd_pkg::res_t decode_byte(input logic [7:0] stored);
    wrsd_pkg::res_t r;
    logic [7:0]     b;
    logic [1:0]     done_len;
    logic [16:0]    idx;
    logic           letter;
    r = '0;
    done_len = '0;
    idx = '0;
    if (hdr_pos < wrsd_pkg::HdrDone) begin
      if (hdr_pos == wrsd_pkg::HdrType) begin
        if (stored != wrsd_pkg::HeaderMagic) begin
          r.kind = wrsd_pkg::KIND_ERROR;
          r.error_code = wrsd_pkg::ERR_TYPE;
        end
      end else if (hdr_pos < wrsd_pkg::HdrMarker) begin
        len_reg = {len_reg[23:0], stored};
      end else if (stored != wrsd_pkg::HeaderMagic) begin
        r.kind = wrsd_pkg::KIND_ERROR;
        r.error_code = wrsd_pkg::ERR_MARKER;
      end
      hdr_pos = hdr_pos + 3'd1;
    end else begin
      b = undo_byte_map(stored);
      if (esc_pend) begin
        upper_on = 1'b0;
        esc_pend = 1'b0;
        r.kind = wrsd_pkg::KIND_LITERAL;
        r.out_byte = b;
      end else if (code_need != 2'd0) begin
        if (code_have == 2'd1) begin
          code_b1 = b;
          if (b > wrsd_pkg::CodeOneMax) begin
            code_have = 2'd2;
            code_need = 2'd1;
          end else begin
            done_len = 2'd2;
          end
        end else begin
          done_len = 2'd3;
        end
        if (done_len != 2'd0) begin
          idx = code_to_index(done_len, code_b0, code_b1, b);
          code_need = 2'd0;
        end
      end else if (b == wrsd_pkg::CtrlEscape) begin
        esc_pend = 1'b1;
      end else if (b == wrsd_pkg::CtrlUpper) begin
        upper_on = 1'b1;
      end else if (b == wrsd_pkg::CtrlCapital) begin
        cap_pend = 1'b1;
      end else if (b == wrsd_pkg::CtrlUpperOff) begin
        upper_on = 1'b0;
      end else if (b >= wrsd_pkg::CodeOneMin) begin
        code_b0 = b;
        code_have = 2'd1;
        if (b > wrsd_pkg::CodeOneMax) begin
          code_need = 2'd1;
        end else begin
          done_len = 2'd1;
          idx = code_to_index(2'd1, b, 8'd0, 8'd0);
        end
      end else begin
        letter = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
        if (!letter) upper_on = 1'b0;
        if (cap_pend || upper_on) b = b - wrsd_pkg::CaseOffset;
        cap_pend = 1'b0;
        r.kind = wrsd_pkg::KIND_LITERAL;
        r.out_byte = b;
      end
      if (done_len != 2'd0) begin
        if (idx >= {1'b0, words_loaded}) begin
          r.kind = wrsd_pkg::KIND_ERROR;
          r.error_code = wrsd_pkg::ERR_UNKNOWN;
        end else begin
          r.kind = wrsd_pkg::KIND_WORD;
          r.word_index = idx[15:0];
          r.first_capital = cap_pend;
          r.all_upper = upper_on;
        end
        cap_pend = 1'b0;
        code_b0 = '0;
        code_b1 = '0;
        code_have = '0;
        code_need = '0;
      end
    end
    r.declared_length = len_reg;
    r.mid_sequence = esc_pend || (code_need != 2'd0);
    return r;
  endfunction

  task automatic check_result(input wrsd_pkg::res_t want);
    if (m_axis_tuser != want.kind) flag_mismatch("kind", m_axis_tuser, want.kind);
    if (m_axis_tdata[7:0] != want.out_byte)
      flag_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
    if (m_axis_tdata[23:8] != want.word_index)
      flag_mismatch("word_index", m_axis_tdata[23:8], want.word_index);
    if (m_axis_tdata[24] != want.first_capital)
      flag_mismatch("first_capital", m_axis_tdata[24], want.first_capital);
    if (m_axis_tdata[25] != want.all_upper)
      flag_mismatch("all_upper", m_axis_tdata[25], want.all_upper);
    if (m_axis_tdata[27:26] != want.error_code)
      flag_mismatch("error_code", m_axis_tdata[27:26], want.error_code);
    if (m_axis_tdata[59:28] != want.declared_length)
      flag_mismatch("declared_length", m_axis_tdata[59:28], want.declared_length);
    if (m_axis_tdata[60] != want.mid_sequence)
      flag_mismatch("mid_sequence", m_axis_tdata[60], want.mid_sequence);
  endtask

  // stream driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stored_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stored_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: results are checked before this edge's input is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
        end else begin
          oldest = pending_results.pop_front();
          check_result(oldest);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.insert(pending_results.size(), decode_byte(s_axis_tdata));
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (wr && addr == WordCountAddr) words_loaded = data[15:0];
    if (!wr && prdata[15:0] != words_loaded)
      flag_mismatch("word_count readback", prdata[15:0], words_loaded);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_word_count(input logic [2:0] addr, input logic [15:0] value);
    apb_access(1'b1, addr, {16'd0, value});
    apb_access(1'b0, WordCountAddr, 32'd0);
  endtask

  task automatic push_raw(input logic [7:0] v);
    stored_q.insert(stored_q.size(), v);
    queued_total++;
  endtask

  task automatic push_plain(input logic [7:0] v);
    push_raw(stored_for[v]);
  endtask

  task automatic push_word(input int unsigned idx);
    int unsigned row;
    if (idx < wrsd_pkg::TwoByteBase) begin
      push_plain(8'(wrsd_pkg::CodeOneMin + idx));
    end else if (idx < wrsd_pkg::ThreeByteBase) begin
      push_plain(8'(wrsd_pkg::CodeTwoMin
                    + (idx - wrsd_pkg::TwoByteBase) / wrsd_pkg::WordsPerRow));
      push_plain(8'(wrsd_pkg::CodeOneMin
                    + (idx - wrsd_pkg::TwoByteBase) % wrsd_pkg::WordsPerRow));
    end else begin
      row = (idx - wrsd_pkg::ThreeByteBase) / wrsd_pkg::WordsPerRow;
      push_plain(8'(wrsd_pkg::CodeThreeMin + row / 32));
      push_plain(8'(wrsd_pkg::CodeTwoMin + row % 32));
      push_plain(8'(wrsd_pkg::CodeOneMin
                    + (idx - wrsd_pkg::ThreeByteBase) % wrsd_pkg::WordsPerRow));
    end
  endtask

  function automatic int unsigned pick_index();
    int sel, v;
    sel = $urandom_range(9);
    if (sel < 3) begin
      v = int'(words_loaded) + int'($urandom_range(3)) - 2;
      if (v < 0) v = 0;
      if (v > LastWord) v = LastWord;
    end else if (sel < 5) begin
      v = $urandom_range(wrsd_pkg::TwoByteBase - 1);
    end else if (sel < 7) begin
      v = $urandom_range(wrsd_pkg::ThreeByteBase - 1, wrsd_pkg::TwoByteBase);
    end else begin
      v = $urandom_range(LastWord, wrsd_pkg::ThreeByteBase);
    end
    return v;
  endfunction

  task automatic add_random_text(input int n);
    int start, sel;
    start = queued_total;
    while (queued_total - start < n) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        if ($urandom_range(1) != 0) push_plain(8'(8'h61 + $urandom_range(25)));
        else push_plain(8'(8'h41 + $urandom_range(25)));
      end else if (sel < 40) begin
        push_plain(8'($urandom_range(8'h7F)));
      end else if (sel < 50) begin
        case ($urandom_range(3))
          0: begin
            push_plain(wrsd_pkg::CtrlEscape);
            push_plain(8'($urandom_range(255)));
          end
          1: push_plain(wrsd_pkg::CtrlUpper);
          2: push_plain(wrsd_pkg::CtrlCapital);
          default: push_plain(wrsd_pkg::CtrlUpperOff);
        endcase
      end else if (sel < 80) begin
        push_word(pick_index());
      end else if (sel < 90) begin
        push_plain(($urandom_range(1) != 0) ? wrsd_pkg::CtrlCapital : wrsd_pkg::CtrlUpper);
        push_word(pick_index());
      end else begin
        push_raw(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (stored_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) stored_for[undo_byte_map(i[7:0])] = i[7:0];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bad type, length bytes, bad marker
    snd_idle_pct = 14;
    rcv_idle_pct = 87;
    push_raw(8'hFF);
    push_raw(8'hFF);
    push_raw(8'h00);
    push_raw(8'hA5);
    push_raw(8'h5A);
    push_raw(8'h00);
    push_plain(wrsd_pkg::CtrlEscape);
    push_plain(wrsd_pkg::CtrlEscape);
    push_plain(wrsd_pkg::CtrlUpper);
    push_plain(8'h61);
    push_plain(8'h31);
    push_plain(wrsd_pkg::CtrlCapital);
    push_plain(8'h62);
    push_plain(wrsd_pkg::CtrlCapital);
    push_word(5);
    push_plain(wrsd_pkg::CtrlUpper);
    push_word(wrsd_pkg::TwoByteBase);
    push_word(wrsd_pkg::ThreeByteBase);
    push_word(LastWord);
    // control value inside a code is a code byte
    push_plain(wrsd_pkg::CodeTwoMin);
    push_plain(wrsd_pkg::CtrlUpper);
    push_plain(wrsd_pkg::CtrlUpperOff);
    add_random_text(400);
    wait_drained();

    set_word_count(UnusedAddr, 16'd5);
    set_word_count(WordCountAddr, 16'd0);
    @(negedge clk_i);
    add_random_text(200);
    wait_drained();

    set_word_count(WordCountAddr, wrsd_pkg::ThreeByteBase);
    @(negedge clk_i);
    snd_idle_pct = 87;
    rcv_idle_pct = 14;
    add_random_text(400);
    wait_drained();

    set_word_count(WordCountAddr, wrsd_pkg::TwoByteBase);
    @(negedge clk_i);
    add_random_text(200);
    wait_drained();

    set_word_count(WordCountAddr, wrsd_pkg::WordCountRst);
    @(negedge clk_i);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_armed = 1'b1;
    add_random_text(450);
    wait_drained();

    repeat (4) @(posedge clk_i);
    if (error_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
